// ===== rtl/ers_pkg.sv =====
// ============================================================================
// Elevator request scheduler package
// Shared widths, reset values and direction codes.
// ============================================================================
package ers_pkg;

  localparam int ERS_NUM_FLOORS = 8;

  localparam int FLR_W  = 4;
  localparam int MOVE_W = 3;
  localparam int CALL_W = 8;
  localparam int DIR_W  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FLR_W-1:0]  PARK_FLOOR_RST = FLR_W'(5);
  localparam logic [FLR_W-1:0]  CAR_FLOOR_RST  = FLR_W'(1);
  localparam logic [MOVE_W-1:0] MOVE_MAX       = '1;

  // register index of park_floor
  localparam logic [CFG_ADDR_W-3:0] REG_PARK_FLOOR = '0;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

endpackage

// ===== rtl/ers_req_if.sv =====
// ============================================================================
// Elevator request channel
// Valid/ready channel carrying one control tick.
// ============================================================================
interface ers_req_if;
  import ers_pkg::*;

  logic             valid;
  logic             ready;
  logic [FLR_W-1:0] floor_key;
  logic             idle_timeout;

  modport source (output valid, floor_key, idle_timeout, input ready);
  modport sink   (input valid, floor_key, idle_timeout, output ready);
endinterface

// ===== rtl/ers_rsp_if.sv =====
// ============================================================================
// Elevator result channel
// Valid/ready channel carrying the car status after one tick.
// ============================================================================
interface ers_rsp_if;
  import ers_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLR_W-1:0]  floor_now;
  logic [DIR_W-1:0]  travel_dir;
  logic [FLR_W-1:0]  target_floor;
  logic [DIR_W-1:0]  motor_cmd;
  logic [MOVE_W-1:0] floors_moved;
  logic              door_open;
  logic [CALL_W-1:0] pending_calls;

  modport source (output valid, floor_now, travel_dir, target_floor, motor_cmd,
                  floors_moved, door_open, pending_calls, input ready);
  modport sink   (input valid, floor_now, travel_dir, target_floor, motor_cmd,
                  floors_moved, door_open, pending_calls, output ready);
endinterface

// ===== rtl/elevator_request_scheduler_core.sv =====
// ============================================================================
// Elevator request scheduler core
// LOOK-style car scheduler: one request per control tick, park on timeout.
// ============================================================================
//
//   channel   dir  handshake              payload
//   in_req    in   valid/ready            floor_key, idle_timeout
//   out_rsp   out  valid/ready            floor_now .. pending_calls
//   cfg_*     in   APB, pready tied high  park_floor at byte address 0
//
// One request per cycle sustained while results are taken; a request waits in
// the input register and loads the result register when it fires.
// The input register feeds one combinational tick update that writes the car
// state and the result register at the same edge.
// rst_n is synchronous; the park floor resets to 5, no clearing pass.
// A stalled result holds the state update; in_req.ready drops only when both
// the input register and the result register are full.
// ============================================================================
module elevator_request_scheduler_core #(
  parameter int NUM_FLOORS = ers_pkg::ERS_NUM_FLOORS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ers_req_if.sink                         in_req,
  ers_rsp_if.source                       out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ers_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ers_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ers_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import ers_pkg::*;

  function automatic logic [NUM_FLOORS-1:0] floor_bit(input logic [FLR_W-1:0] f);
    logic [NUM_FLOORS-1:0] b;
    for (int i = 0; i < NUM_FLOORS; i++) b[i] = (32'(f) == 32'(i + 1));
    return b;
  endfunction

  logic                  req_v_r;
  logic [FLR_W-1:0]      req_key_r;
  logic                  req_tmo_r;
  logic                  fire;

  logic [FLR_W-1:0]      park_floor_r;
  logic                  park_sel;

  logic [NUM_FLOORS-1:0] map_r, map_nxt;
  logic [FLR_W-1:0]      car_floor_r, car_floor_nxt;
  dir_t                  dir_r, dir_nxt;
  logic [FLR_W-1:0]      goal_r, goal_nxt;
  logic                  park_pend_r, park_pend_nxt;
  dir_t                  motor_nxt;
  logic [MOVE_W-1:0]     moved_nxt;
  logic                  door_nxt;

  logic                  out_v_r;
  logic [FLR_W-1:0]      o_floor_r;
  dir_t                  o_dir_r;
  logic [FLR_W-1:0]      o_goal_r;
  dir_t                  o_motor_r;
  logic [MOVE_W-1:0]     o_moved_r;
  logic                  o_door_r;
  logic [CALL_W-1:0]     o_calls_r;

  // configuration port
  assign park_sel   = (cfg_paddr[CFG_ADDR_W-1:2] == REG_PARK_FLOOR);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = park_sel ? CFG_DATA_W'(park_floor_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      park_floor_r <= PARK_FLOOR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && park_sel) begin
      park_floor_r <= cfg_pwdata[FLR_W-1:0];
    end
  end

  // input register
  assign fire         = req_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !req_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_req.ready) begin
      req_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_key_r <= in_req.floor_key;
      req_tmo_r <= in_req.idle_timeout;
    end
  end

  // tick update
  always_comb begin
    logic [NUM_FLOORS-1:0] map_v;
    logic [NUM_FLOORS-1:0] cur_bit;
    logic [NUM_FLOORS-1:0] below;
    logic [FLR_W-1:0]      flr_v;
    logic [FLR_W-1:0]      goal_v;
    logic [FLR_W-1:0]      dist_v;
    logic [FLR_W-1:0]      near_dn;
    logic [FLR_W-1:0]      near_up;
    logic                  found_dn;
    logic                  found_up;
    logic                  pend_v;
    logic                  park_ok;
    dir_t                  dir_v;

    map_v     = map_r | floor_bit(req_key_r);
    pend_v    = park_pend_r | req_tmo_r;
    dir_v     = dir_r;
    flr_v     = car_floor_r;
    goal_v    = goal_r;
    motor_nxt = DIR_STOP;
    moved_nxt = '0;
    door_nxt  = 1'b0;
    dist_v    = '0;
    park_ok   = (park_floor_r != '0) && (32'(park_floor_r) <= 32'(NUM_FLOORS));

    if (pend_v && dir_r == DIR_STOP && park_ok && car_floor_r != park_floor_r) begin
      if (car_floor_r > park_floor_r) begin
        dir_v     = DIR_DOWN;
        motor_nxt = DIR_DOWN;
        dist_v    = car_floor_r - park_floor_r;
      end else begin
        dir_v     = DIR_UP;
        motor_nxt = DIR_UP;
        dist_v    = park_floor_r - car_floor_r;
      end
      moved_nxt = (dist_v > FLR_W'(MOVE_MAX)) ? MOVE_MAX : dist_v[MOVE_W-1:0];
      pend_v    = 1'b0;
      goal_v    = park_floor_r;
      flr_v     = park_floor_r;
      map_v     = map_v & ~floor_bit(park_floor_r);
    end

    cur_bit = floor_bit(flr_v);
    if (map_v != '0 && dir_v == DIR_STOP) begin
      if (map_v < cur_bit) begin
        dir_v = DIR_DOWN;
      end else if (map_v > cur_bit) begin
        dir_v = DIR_UP;
      end
    end

    for (int i = 0; i < NUM_FLOORS; i++) below[i] = (32'(i + 1) < 32'(flr_v));

    found_dn = 1'b0;
    near_dn  = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (map_v[i] && below[i]) begin
        found_dn = 1'b1;
        near_dn  = FLR_W'(i + 1);
      end
    end

    found_up = 1'b0;
    near_up  = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (map_v[i] && !below[i]) begin
        found_up = 1'b1;
        near_up  = FLR_W'(i + 1);
      end
    end

    if (dir_v == DIR_DOWN && map_v != '0) begin
      if (found_dn) begin
        if (goal_v == '0 || goal_v < near_dn) goal_v = near_dn;
      end else begin
        dir_v  = DIR_STOP;
        goal_v = '0;
      end
    end else if (dir_v == DIR_UP && map_v != '0) begin
      if (found_up) begin
        if (goal_v == '0 || goal_v > near_up) goal_v = near_up;
      end else begin
        dir_v  = DIR_STOP;
        goal_v = '0;
      end
    end

    if (goal_v != '0) begin
      priority if (goal_v < flr_v) begin
        flr_v     = flr_v - FLR_W'(1);
        map_v     = map_v & ~floor_bit(flr_v);
        motor_nxt = DIR_DOWN;
        moved_nxt = (moved_nxt == MOVE_MAX) ? MOVE_MAX : moved_nxt + MOVE_W'(1);
      end else if (goal_v > flr_v) begin
        flr_v     = flr_v + FLR_W'(1);
        map_v     = map_v & ~floor_bit(flr_v);
        motor_nxt = DIR_UP;
        moved_nxt = (moved_nxt == MOVE_MAX) ? MOVE_MAX : moved_nxt + MOVE_W'(1);
      end else begin
        goal_v   = '0;
        door_nxt = 1'b1;
        map_v    = map_v & ~floor_bit(flr_v);
      end
    end

    map_nxt       = map_v;
    car_floor_nxt = flr_v;
    dir_nxt       = dir_v;
    goal_nxt      = goal_v;
    park_pend_nxt = pend_v;
  end

  // car state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      car_floor_r <= CAR_FLOOR_RST;
      dir_r       <= DIR_STOP;
      goal_r      <= '0;
      park_pend_r <= 1'b0;
    end else if (fire) begin
      map_r       <= map_nxt;
      car_floor_r <= car_floor_nxt;
      dir_r       <= dir_nxt;
      goal_r      <= goal_nxt;
      park_pend_r <= park_pend_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_floor_r <= car_floor_nxt;
      o_dir_r   <= dir_nxt;
      o_goal_r  <= goal_nxt;
      o_motor_r <= motor_nxt;
      o_moved_r <= moved_nxt;
      o_door_r  <= door_nxt;
      o_calls_r <= CALL_W'(map_nxt);
    end
  end

  assign out_rsp.valid         = out_v_r;
  assign out_rsp.floor_now     = o_floor_r;
  assign out_rsp.travel_dir    = o_dir_r;
  assign out_rsp.target_floor  = o_goal_r;
  assign out_rsp.motor_cmd     = o_motor_r;
  assign out_rsp.floors_moved  = o_moved_r;
  assign out_rsp.door_open     = o_door_r;
  assign out_rsp.pending_calls = o_calls_r;

  a_car_floor_valid: assert property (@(posedge clk) disable iff (!rst_n)
    car_floor_r != '0)
    else $error("car floor left the valid range");

  a_door_clears_goal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && o_door_r) |-> (o_goal_r == '0))
    else $error("door opened with a target still set");

  a_stop_no_goal: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == DIR_STOP) |-> (goal_r == '0))
    else $error("stopped car holds a target");

  a_motion_moved: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((o_motor_r == DIR_STOP) == (o_moved_r == '0)))
    else $error("motor command and floor count disagree");

endmodule
